[hw/rtl/rmsn_pkg.sv]
// Shared types and constants for the RMS row normalizer.
`timescale 1ns / 1ps
package rmsn_pkg;
    localparam int DATA_W  = 16;
    localparam int CNT_W   = 7;
    localparam int EPS_W   = 16;
    localparam int SUM_W   = 38;
    localparam int MS_W    = 39;
    localparam int ROOT_W  = 28;
    localparam int QUO_W   = 17;

    localparam logic [CNT_W-1:0] ROW_LENGTH_RST = 7'd64;
    localparam logic [EPS_W-1:0] EPS_LEVEL_RST  = 16'd17;

    localparam logic REG_ROW_LENGTH = 1'b0;
    localparam logic REG_EPS_LEVEL  = 1'b1;

    localparam logic signed [DATA_W-1:0] Y_MAX = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] Y_MIN = 16'sh8000;

    typedef struct packed {
        logic             valid;
        logic             bank;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
    } job_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } done_t;
endpackage

[hw/rtl/rmsn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rmsn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

[hw/rtl/rmsn_front.sv]
// Front end: takes row words, stores them in a free bank, sums squares, posts row jobs.
`timescale 1ns / 1ps
module rmsn_front #(
    parameter int MAX_ROW = 64,
    parameter int IDX_W   = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [15:0]            x_value,
    input  logic signed [15:0]            gamma_value,
    input  logic [6:0]                    row_length,
    input  logic                          q_full,
    input  rmsn_pkg::done_t               done,
    output rmsn_pkg::job_t                push,
    output logic                          wr_en,
    output logic [IDX_W:0]                wr_addr,
    output logic [31:0]                   wr_data
);
    import rmsn_pkg::*;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              bank_reg, bank_next;
    logic [1:0]        busy_reg, busy_next;
    logic [CNT_W-1:0]  eff;
    logic [CNT_W-1:0]  cnt_new;
    logic [SUM_W-1:0]  sum_new;
    logic signed [31:0] sq;
    logic              acc;
    logic              complete;

    always_comb
    begin
        if (row_length == '0)
            eff = CNT_W'(1);
        else if (row_length > CNT_W'(MAX_ROW))
            eff = CNT_W'(MAX_ROW);
        else
            eff = row_length;
    end

    assign in_stall = busy_reg[bank_reg] || q_full;
    assign acc      = in_valid && !in_stall;
    assign sq       = x_value * x_value;
    assign sum_new  = sum_reg + SUM_W'(unsigned'(sq));
    assign cnt_new  = cnt_reg + CNT_W'(1);
    assign complete = cnt_new >= eff;

    assign wr_en   = acc;
    assign wr_addr = {bank_reg, cnt_reg[IDX_W-1:0]};
    assign wr_data = {x_value, gamma_value};

    always_comb
    begin
        push.valid = acc && complete;
        push.bank  = bank_reg;
        push.count = cnt_new;
        push.sum   = sum_new;
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        if (done.valid)
            busy_next[done.bank] = 1'b0;
        if (acc)
        begin
            if (complete)
            begin
                cnt_next            = '0;
                sum_next            = '0;
                bank_next           = !bank_reg;
                busy_next[bank_reg] = 1'b1;
            end
            else
            begin
                cnt_next = cnt_new;
                sum_next = sum_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            sum_reg  <= '0;
            bank_reg <= 1'b0;
            busy_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            sum_reg  <= sum_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end
endmodule

[hw/rtl/rmsn_back.sv]
// Back end: mean square divide, square root, per-word divide and output register.
`timescale 1ns / 1ps
module rmsn_back #(
    parameter int IDX_W = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  rmsn_pkg::job_t         job,
    output logic                   pop,
    output logic                   rd_en,
    output logic [IDX_W:0]         rd_addr,
    input  logic [31:0]            rd_data,
    input  logic [15:0]            eps_level,
    output rmsn_pkg::done_t        done,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [15:0]     y_value,
    output logic                   last
);
    import rmsn_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MSDIV  = 8'b0000_0010,
        S_SQRT   = 8'b0000_0100,
        S_RD     = 8'b0000_1000,
        S_LOAD   = 8'b0001_0000,
        S_QSTART = 8'b0010_0000,
        S_QDIV   = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic                bank_reg, bank_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [5:0]          step_reg, step_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]    drem_reg, drem_next;
    logic [55:0]         v_reg, v_next;
    logic [29:0]         srem_reg, srem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [30:0]         mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [28:0]         qrem_reg, qrem_next;
    logic [QUO_W-1:0]    qsh_reg, qsh_next;
    logic [QUO_W-1:0]    q_reg, q_next;
    logic signed [15:0]  yv_reg, yv_next;
    logic                out_valid_reg;
    logic signed [15:0]  y_out_reg;
    logic                last_reg;

    logic [CNT_W:0]      d_rs;
    logic                d_ge;
    logic [MS_W-1:0]     ms;
    logic [31:0]         s_t;
    logic [29:0]         s_trial;
    logic                s_ge;
    logic signed [31:0]  prod;
    logic [31:0]         prod_mag;
    logic [38:0]         dvd;
    logic                q_sat;
    logic [29:0]         q_t;
    logic                q_ge;
    logic [QUO_W-1:0]    qv;
    logic                out_free;
    logic                is_last;

    assign out_free = !out_valid_reg || !out_stall;
    assign is_last  = (k_reg == n_reg - CNT_W'(1));

    assign d_rs = {drem_reg, quo_reg[SUM_W-1]};
    assign d_ge = d_rs >= {1'b0, n_reg};
    // mean square from the quotient including the bit resolved this cycle
    assign ms   = MS_W'({quo_reg[SUM_W-2:0], d_ge}) + MS_W'(eps_level);

    assign s_t     = {srem_reg, v_reg[55:54]};
    assign s_trial = {root_reg, 2'b01};
    assign s_ge    = s_t >= 32'(s_trial);

    assign prod     = signed'(rd_data[31:16]) * signed'(rd_data[15:0]);
    assign prod_mag = prod[31] ? 32'(-prod) : prod;
    assign dvd      = {mag_reg, 8'b0};
    assign q_sat    = {6'b0, dvd} >= {root_reg, 17'b0};

    assign q_t  = {qrem_reg, qsh_reg[QUO_W-1]};
    assign q_ge = q_t >= 30'(root_reg);
    assign qv   = {q_reg[QUO_W-2:0], q_ge};

    assign pop     = (state_reg == S_IDLE) && q_valid;
    assign rd_en   = (state_reg == S_RD);
    assign rd_addr = {bank_reg, k_reg[IDX_W-1:0]};

    always_comb
    begin
        done.valid = (state_reg == S_EMIT) && out_free && is_last;
        done.bank  = bank_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        bank_next  = bank_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        quo_next   = quo_reg;
        drem_next  = drem_reg;
        v_next     = v_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        qrem_next  = qrem_reg;
        qsh_next   = qsh_reg;
        q_next     = q_reg;
        yv_next    = yv_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    bank_next  = job.bank;
                    n_next     = job.count;
                    quo_next   = job.sum;
                    drem_next  = '0;
                    step_next  = '0;
                    state_next = S_MSDIV;
                end
            end
            S_MSDIV:
            begin
                drem_next = d_ge ? CNT_W'(d_rs - {1'b0, n_reg}) : d_rs[CNT_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], d_ge};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(SUM_W - 1))
                begin
                    state_next = S_SQRT;
                    step_next  = '0;
                end
            end
            S_SQRT:
            begin
                srem_next = s_ge ? 30'(s_t - 32'(s_trial)) : s_t[29:0];
                root_next = {root_reg[ROOT_W-2:0], s_ge};
                v_next    = {v_reg[53:0], 2'b00};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(ROOT_W - 1))
                begin
                    state_next = S_RD;
                    k_next     = '0;
                end
            end
            S_RD:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                neg_next   = prod[31];
                mag_next   = prod_mag[30:0];
                state_next = S_QSTART;
            end
            S_QSTART:
            begin
                qrem_next = 29'(dvd[38:17]);
                qsh_next  = dvd[16:0];
                q_next    = '0;
                step_next = '0;
                if (root_reg == '0)
                begin
                    yv_next    = '0;
                    state_next = S_EMIT;
                end
                else if (q_sat)
                begin
                    yv_next    = neg_reg ? Y_MIN : Y_MAX;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_QDIV;
                end
            end
            S_QDIV:
            begin
                qrem_next = q_ge ? 29'(q_t - 30'(root_reg)) : q_t[28:0];
                qsh_next  = {qsh_reg[QUO_W-2:0], 1'b0};
                q_next    = qv;
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(QUO_W - 1))
                begin
                    if (neg_reg)
                        yv_next = (qv > 17'd32768) ? Y_MIN : 16'(-qv);
                    else
                        yv_next = (qv > 17'd32767) ? Y_MAX : signed'(qv[15:0]);
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = is_last ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_MSDIV && step_reg == 6'(SUM_W - 1))
        begin
            srem_next = '0;
            root_next = '0;
            v_next    = {1'b0, ms, 16'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_free)
                out_valid_reg <= (state_reg == S_EMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg <= bank_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        step_reg <= step_next;
        quo_reg  <= quo_next;
        drem_reg <= drem_next;
        v_reg    <= v_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        qrem_reg <= qrem_next;
        qsh_reg  <= qsh_next;
        q_reg    <= q_next;
        yv_reg   <= yv_next;
        if (out_free && state_reg == S_EMIT)
        begin
            y_out_reg <= yv_reg;
            last_reg  <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign y_value   = y_out_reg;
    assign last      = last_reg;
endmodule

[hw/rtl/rms_normalization_row.sv]
// Top level of the RMS row normalizer: config registers, row job queue, front and back ends.
`timescale 1ns / 1ps
// Streams rows of Q4.12 (x, gamma) words and returns y = x*gamma/rms per word, Q4.12,
// saturated, with last on the final word of each row. Input words are taken one per
// cycle, while in_stall is low, into one of two row banks; a row is handed to the back
// end when row_length words have arrived, and the next row loads into the other bank
// meanwhile. Per row the back end runs a bit-serial mean-square divide and a bit-serial
// square root, then for each output word a read, a multiply, a setup, the 17 steps of
// its bit-serial quotient divider and a hand-off; a saturated or zero-root word skips the
// divide steps. The input stalls only when both banks hold rows not yet fully emitted.
module rms_normalization_row #(
    parameter int MAX_ROW = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] x_value,
    input  logic signed [15:0] gamma_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] y_value,
    output logic               last
);
    import rmsn_pkg::*;

    localparam int IDX_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
    localparam int DEPTH = 2 << IDX_W;

    logic [CNT_W-1:0] row_length_reg;
    logic [EPS_W-1:0] eps_level_reg;
    logic             cfg_wr;

    job_t             push;
    job_t             q_mem_reg [2];
    logic             q_wp_reg, q_rp_reg;
    logic [1:0]       q_cnt_reg;
    logic             q_full, q_valid, pop;
    done_t            done;

    logic             wr_en, rd_en;
    logic [IDX_W:0]   wr_addr, rd_addr;
    logic [31:0]      wr_data, rd_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_EPS_LEVEL) ? {16'b0, eps_level_reg}
                                                 : {25'b0, row_length_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= ROW_LENGTH_RST;
            eps_level_reg  <= EPS_LEVEL_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ROW_LENGTH: row_length_reg <= pwdata[CNT_W-1:0];
                REG_EPS_LEVEL:  eps_level_reg  <= pwdata[EPS_W-1:0];
                default:        row_length_reg <= row_length_reg;
            endcase
        end
    end

    assign q_full  = (q_cnt_reg == 2'd2);
    assign q_valid = (q_cnt_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg  <= 1'b0;
            q_rp_reg  <= 1'b0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (push.valid)
                q_wp_reg <= !q_wp_reg;
            if (pop)
                q_rp_reg <= !q_rp_reg;
            q_cnt_reg <= q_cnt_reg + 2'(push.valid) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            q_mem_reg[q_wp_reg] <= push;
    end

    rmsn_front #(
        .MAX_ROW (MAX_ROW),
        .IDX_W   (IDX_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .x_value     (x_value),
        .gamma_value (gamma_value),
        .row_length  (row_length_reg),
        .q_full      (q_full),
        .done        (done),
        .push        (push),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    rmsn_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rmsn_back #(
        .IDX_W (IDX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .job       (q_mem_reg[q_rp_reg]),
        .pop       (pop),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .eps_level (eps_level_reg),
        .done      (done),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .y_value   (y_value),
        .last      (last)
    );
endmodule

[tb/rmsn_checker.sv]
// Checker for the RMS row normalizer: predicts each row's outputs and compares them.
`timescale 1ns / 1ps
module rmsn_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] x_value,
    input  logic signed [15:0] gamma_value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] y_value,
    input  logic               last,
    input  logic [6:0]         row_length_cfg,
    input  logic [15:0]        eps_cfg,
    output int                 fail_count,
    output int                 pending
);
    import rmsn_pkg::*;

    typedef struct packed {
        logic signed [15:0] y;
        logic               last;
    } word_t;

    word_t              y_expected[$];
    logic signed [15:0] x_row[64];
    logic signed [15:0] g_row[64];
    logic [37:0]        sq_sum;
    int                 row_fill;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] scale_word(logic signed [15:0] x,
                                                      logic signed [15:0] g,
                                                      logic [63:0] r);
        longint     p;
        logic [63:0] mag;
        logic [63:0] q;
        if (r == 0)
            return 16'sd0;
        p = longint'(x) * longint'(g);
        mag = (p < 0) ? 64'(-p) : 64'(p);
        q = (mag << 8) / r;
        if (p < 0)
            return (q > 64'd32768) ? Y_MIN : 16'(-longint'(q));
        return (q > 64'd32767) ? Y_MAX : 16'(q);
    endfunction

    task automatic take_element(logic signed [15:0] x, logic signed [15:0] g);
        int          idx;
        int          eff;
        logic [63:0] ms;
        logic [63:0] r;
        word_t       w;
        idx = (row_fill >= 64) ? 63 : row_fill;
        x_row[idx] = x;
        g_row[idx] = g;
        sq_sum = sq_sum + 38'(longint'(x) * longint'(x));
        row_fill = idx + 1;
        eff = (row_length_cfg == 0) ? 1 : (row_length_cfg > 64) ? 64 : row_length_cfg;
        if (row_fill < eff)
            return;
        ms = 64'(sq_sum) / 64'(row_fill) + 64'(eps_cfg);
        r = int_sqrt(ms << 16);
        for (int k = 0; k < row_fill; k++)
        begin
            w.y = scale_word(x_row[k], g_row[k], r);
            w.last = (k + 1 == row_fill);
            y_expected.push_back(w);
        end
        sq_sum = 0;
        row_fill = 0;
    endtask

    task automatic report(string what, logic signed [15:0] got, logic signed [15:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        sq_sum = 0;
        row_fill = 0;
    end

    always @(posedge clk)
    begin
        word_t w;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                take_element(x_value, gamma_value);
            if (out_valid && !out_stall)
            begin
                if (y_expected.size() == 0)
                    report("unexpected word", y_value, 0);
                else
                begin
                    w = y_expected.pop_front();
                    if (y_value !== w.y)
                        report("y_value", y_value, w.y);
                    if (last !== w.last)
                        report("last", 16'(last), 16'(w.last));
                end
            end
        end
        pending = y_expected.size();
    end
endmodule

[tb/tb.sv]
// Testbench top for the RMS row normalizer: stimulus, register writes and verdict.
`timescale 1ns / 1ps
module tb;
    import rmsn_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               psel = 0;
    logic               penable = 0;
    logic               pwrite = 0;
    logic [2:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 0;
    logic               in_stall;
    logic signed [15:0] x_value = 0;
    logic signed [15:0] gamma_value = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic signed [15:0] y_value;
    logic               last;
    logic [6:0]         row_length_cfg = ROW_LENGTH_RST;
    logic [15:0]        eps_cfg = EPS_LEVEL_RST;
    int                 fail_count;
    int                 pending;
    int                 cycle = 0;
    bit                 hold_off = 0;
    bit                 stall_quiet = 0;

    localparam int LIMIT = 3000000;

    rms_normalization_row dut (.*);

    rmsn_checker checker_i (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= LIMIT)
        begin
            $display("rms_normalization_row test failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver stall process
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_stall <= 1;
                repeat (3000) @(posedge clk);
                hold_off = 0;
            end
            n = stall_quiet ? 0 : gap_len();
            out_stall <= (n != 0);
            repeat (n > 0 ? n : 1) @(posedge clk);
        end
    end

    task automatic reg_write(logic idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= 3'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (idx == REG_ROW_LENGTH)
            row_length_cfg = val[6:0];
        else
            eps_cfg = val[15:0];
    endtask

    task automatic send(logic signed [15:0] x, logic signed [15:0] g, bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0)
        begin
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1;
        x_value <= x;
        gamma_value <= g;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic go_idle();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (1500) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_field();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return 16'h8000;
        if (p == 1) return 16'h7fff;
        if (p < 5) return 16'($signed($urandom_range(0, 8191)) - 4096);
        return 16'($urandom);
    endfunction

    task automatic random_rows(int total);
        for (int i = 0; i < total; i++)
            send(rand_field(), rand_field(), 1'b1);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1;
        // zero root: all x zero, eps zero; row of 1
        reg_write(REG_ROW_LENGTH, 1);
        reg_write(REG_EPS_LEVEL, 0);
        send(0, 16'sh7fff, 0);
        send(0, 16'sh8000, 0);
        go_idle();
        reg_write(REG_EPS_LEVEL, 65535);
        reg_write(REG_ROW_LENGTH, 0);
        send(16'sh8000, 16'sh8000, 0);
        send(16'sh7fff, 16'sh8000, 0);
        send(1, 16'sh7fff, 0);
        go_idle();
        reg_write(REG_ROW_LENGTH, 4);
        reg_write(REG_EPS_LEVEL, 17);
        send(16'sh8000, 16'sh7fff, 0);
        send(16'sh7fff, 16'sh7fff, 0);
        send(16'sh1000, 16'sh1000, 0);
        send(-16'sh1000, 16'sh1000, 0);
        send(16'sh0001, 16'sh8000, 0);
        send(16'sh0002, 16'sh7000, 0);
        go_idle();
        // shorten length mid-row: row of 2 pending, then length 1
        reg_write(REG_ROW_LENGTH, 1);
        send(16'sh0400, 16'sh1000, 0);
        go_idle();
        // above the maximum acts as 64
        reg_write(REG_ROW_LENGTH, 127);
        for (int i = 0; i < 64; i++)
            send(rand_field(), rand_field(), 0);
        go_idle();
        // pressure: receiver holds off while rows keep arriving
        reg_write(REG_ROW_LENGTH, 3);
        hold_off = 1;
        random_rows(30);
        go_idle();
        reg_write(REG_ROW_LENGTH, 5);
        reg_write(REG_EPS_LEVEL, 0);
        random_rows(80);
        go_idle();
        reg_write(REG_ROW_LENGTH, 1);
        reg_write(REG_EPS_LEVEL, 300);
        stall_quiet = 1;
        random_rows(60);
        go_idle();
        stall_quiet = 0;
        reg_write(REG_ROW_LENGTH, 2);
        reg_write(REG_EPS_LEVEL, 65535);
        random_rows(80);
        go_idle();
        reg_write(REG_ROW_LENGTH, 64);
        reg_write(REG_EPS_LEVEL, 17);
        random_rows(64);
        go_idle();
        if (fail_count == 0)
            $display("rms_normalization_row test passed");
        else
            $display("rms_normalization_row test failed");
        $finish;
    end
endmodule
